// File: rtl/core/povls_pkg.sv
// Shared constants, codes and types of the rotating LED line sequencer.
package povls_pkg;

  localparam int unsigned LED_COUNT   = 48;
  localparam int unsigned LINES_MAX   = 64;
  localparam int unsigned FRAMES_MAX  = 16;
  localparam int unsigned STORE_DEPTH = LINES_MAX * FRAMES_MAX;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned PAT_W    = 48;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned LCOUNT_W = 7;
  localparam int unsigned FCOUNT_W = 5;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned LLOAD_W  = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TONE_LEVELS = 8;
  localparam int unsigned TONE_W      = $clog2(TONE_LEVELS);
  localparam int unsigned STEP_W      = $clog2(CNT_W + 1);

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ROTATION   = 2'd3;

  localparam logic [CNT_W-1:0]    SAT_VALUE           = '1;
  localparam logic [CNT_W-1:0]    LINE_TIME_RESET     = 32'd100000;
  localparam logic [CNT_W-1:0]    FRAME_INTERVAL_RESET = 32'd1000000;
  localparam logic [CNT_W-1:0]    MIN_ROTATION_RESET  = 32'd100000;
  localparam logic [LCOUNT_W-1:0] LINE_COUNT_RESET    = 7'd1;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RESET   = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_DIV,
    ST_LINE,
    ST_TONE_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                start;
    logic [STEP_W-1:0]   steps;
    logic [CNT_W-1:0]    dividend;
    logic [LCOUNT_W-1:0] rem_init;
    logic [LCOUNT_W-1:0] divisor;
  } div_req_t;

endpackage

// File: rtl/core/povls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module povls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/povls_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
module povls_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  povls_pkg::div_req_t                 req_i,
  output logic                                busy_o,
  output logic [povls_pkg::CNT_W-1:0]         quot_o
);

  logic [povls_pkg::STEP_W-1:0]   cnt_q;
  logic [povls_pkg::LCOUNT_W-1:0] rem_q;
  logic [povls_pkg::LCOUNT_W-1:0] rem_d;
  logic [povls_pkg::LCOUNT_W-1:0] dvs_q;
  logic [povls_pkg::CNT_W-1:0]    dvd_q;
  logic [povls_pkg::CNT_W-1:0]    quot_q;
  logic [povls_pkg::LCOUNT_W:0]   trial;
  logic                           fits;

  assign busy_o = (cnt_q != '0);

  always_comb begin
    trial = {rem_q, dvd_q[povls_pkg::CNT_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
    if (fits) begin
      rem_d = povls_pkg::LCOUNT_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = povls_pkg::LCOUNT_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      dvd_q  <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_o) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[povls_pkg::CNT_W-2:0], 1'b0};
      quot_q <= {quot_q[povls_pkg::CNT_W-2:0], fits};
    end
  end

  assign quot_o = quot_q;

endmodule

// File: rtl/core/pov_rotating_led_line_sequencer.sv
// Top level of the rotating LED line sequencer: timers, control and frame store.
// Loads and start commands are done in the idle state, as is a tick with the
// display off. A tick with the display on passes through the line step. A tick
// that accepts a reed edge first runs the bit-serial 32-bit line time divide,
// and a tick that emits a line adds a store read and a tone divide, so the
// serial divider sets how long a tick takes while the output register is free.
// A line that finds the output register still full holds the tick in the emit
// step until the register frees up. The next item is taken while an emitted
// line still waits in the output register. The frame store is 1024 x 48 bits
// and needs no clearing pass.
module pov_rotating_led_line_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [povls_pkg::OP_W-1:0]           operation_i,
  input  logic                                 sensor_level_i,
  input  logic [povls_pkg::FIDX_W-1:0]         load_frame_i,
  input  logic [povls_pkg::LLOAD_W-1:0]        load_line_i,
  input  logic [povls_pkg::PAT_W-1:0]          load_pattern_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [povls_pkg::PAT_W-1:0]          led_pattern_o,
  output logic                                 first_line_o,
  output logic [povls_pkg::TONE_W-1:0]         tone_select_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [povls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [povls_pkg::CNT_W-1:0]          cfg_data_i
);

  povls_pkg::state_e state_q, state_d;

  logic [povls_pkg::LCOUNT_W-1:0] line_count_q;
  logic [povls_pkg::FCOUNT_W-1:0] frame_count_q;
  logic [povls_pkg::CNT_W-1:0]    frame_interval_q;
  logic [povls_pkg::CNT_W-1:0]    min_rotation_q;

  logic                           displaying_q;
  logic                           sensor_prev_q;
  logic [povls_pkg::CNT_W-1:0]    since_edge_q;
  logic [povls_pkg::CNT_W-1:0]    since_line_q;
  logic [povls_pkg::CNT_W-1:0]    since_frame_q;
  logic [povls_pkg::CNT_W-1:0]    line_time_q;
  logic [povls_pkg::LCOUNT_W-1:0] line_index_q;
  logic [povls_pkg::FIDX_W-1:0]   frame_index_q;

  logic                           out_valid_q;
  logic                           first_q;
  logic                           first_out_q;
  logic [povls_pkg::PAT_W-1:0]    led_q;
  logic [povls_pkg::TONE_W-1:0]   tone_q;

  logic                           in_acc;
  logic                           tick_acc;
  logic                           load_acc;
  logic                           start_acc;
  logic [povls_pkg::CNT_W-1:0]    se_inc;
  logic [povls_pkg::CNT_W-1:0]    sl_inc;
  logic [povls_pkg::CNT_W-1:0]    sf_inc;
  logic                           edge_hit;
  logic                           frame_hit;
  logic                           line_hit;
  logic [povls_pkg::LCOUNT_W-1:0] eff_lines;
  logic [povls_pkg::FCOUNT_W-1:0] eff_frames;
  logic [povls_pkg::FCOUNT_W-1:0] frame_inc;
  logic [povls_pkg::FIDX_W-1:0]   frame_adv;
  logic [povls_pkg::FIDX_W-1:0]   frame_wrap;
  logic [povls_pkg::LCOUNT_W-1:0] line_wrap;
  logic                           emit_load;

  logic                           ram_we;
  logic [povls_pkg::ADDR_W-1:0]   ram_waddr;
  logic                           ram_re;
  logic [povls_pkg::ADDR_W-1:0]   ram_raddr;
  logic [povls_pkg::LED_COUNT-1:0] ram_rdata;

  povls_pkg::div_req_t            div_req;
  logic                           div_busy;
  logic [povls_pkg::CNT_W-1:0]    div_quot;

  assign in_ready_o  = (state_q == povls_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign tick_acc    = in_acc & (operation_i == povls_pkg::OP_TICK);
  assign load_acc    = in_acc & (operation_i == povls_pkg::OP_LOAD);
  assign start_acc   = in_acc & (operation_i == povls_pkg::OP_START);

  always_comb begin
    se_inc = (since_edge_q == povls_pkg::SAT_VALUE) ? since_edge_q : since_edge_q + 1'b1;
    sl_inc = (since_line_q == povls_pkg::SAT_VALUE) ? since_line_q : since_line_q + 1'b1;
    sf_inc = (since_frame_q == povls_pkg::SAT_VALUE) ? since_frame_q : since_frame_q + 1'b1;

    if (line_count_q == '0) begin
      eff_lines = povls_pkg::LCOUNT_W'(1);
    end else if (32'(line_count_q) > povls_pkg::LINES_MAX) begin
      eff_lines = povls_pkg::LCOUNT_W'(povls_pkg::LINES_MAX);
    end else begin
      eff_lines = line_count_q;
    end

    if (frame_count_q == '0) begin
      eff_frames = povls_pkg::FCOUNT_W'(1);
    end else if (32'(frame_count_q) > povls_pkg::FRAMES_MAX) begin
      eff_frames = povls_pkg::FCOUNT_W'(povls_pkg::FRAMES_MAX);
    end else begin
      eff_frames = frame_count_q;
    end

    edge_hit  = sensor_prev_q & ~sensor_level_i & (se_inc > min_rotation_q);
    frame_hit = displaying_q & (sf_inc > frame_interval_q);
    frame_inc = povls_pkg::FCOUNT_W'(frame_index_q) + 1'b1;
    frame_adv = (frame_inc >= eff_frames) ? '0 : povls_pkg::FIDX_W'(frame_inc);

    frame_wrap = (povls_pkg::FCOUNT_W'(frame_index_q) >= eff_frames) ? '0 : frame_index_q;
    line_wrap  = (line_index_q >= eff_lines) ? '0 : line_index_q;
  end

  assign ram_we    = load_acc
                   & (32'(load_frame_i) < povls_pkg::FRAMES_MAX)
                   & (32'(load_line_i) < povls_pkg::LINES_MAX);
  assign ram_waddr = povls_pkg::ADDR_W'(load_frame_i) * povls_pkg::ADDR_W'(povls_pkg::LINES_MAX)
                   + povls_pkg::ADDR_W'(load_line_i);
  assign ram_raddr = povls_pkg::ADDR_W'(frame_wrap) * povls_pkg::ADDR_W'(povls_pkg::LINES_MAX)
                   + povls_pkg::ADDR_W'(line_wrap);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      povls_pkg::ST_IDLE: begin
        if (tick_acc) begin
          if (edge_hit) begin
            state_d = povls_pkg::ST_EDGE_DIV;
          end else if (displaying_q) begin
            state_d = povls_pkg::ST_LINE;
          end
        end
      end
      povls_pkg::ST_EDGE_DIV: begin
        if (!div_busy) begin
          state_d = displaying_q ? povls_pkg::ST_LINE : povls_pkg::ST_IDLE;
        end
      end
      povls_pkg::ST_LINE: begin
        state_d = line_hit ? povls_pkg::ST_TONE_DIV : povls_pkg::ST_IDLE;
      end
      povls_pkg::ST_TONE_DIV: begin
        if (!div_busy) begin
          state_d = povls_pkg::ST_EMIT;
        end
      end
      povls_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_d = povls_pkg::ST_IDLE;
        end
      end
      default: state_d = povls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_req          = '0;
    div_req.divisor  = eff_lines;
    line_hit         = 1'b0;
    ram_re           = 1'b0;
    emit_load        = 1'b0;
    unique case (state_q)
      povls_pkg::ST_IDLE: begin
        if (tick_acc && edge_hit) begin
          div_req.start    = 1'b1;
          div_req.steps    = povls_pkg::STEP_W'(povls_pkg::CNT_W);
          div_req.dividend = se_inc;
        end
      end
      povls_pkg::ST_LINE: begin
        line_hit = (since_line_q > line_time_q);
        if (line_hit) begin
          ram_re           = 1'b1;
          div_req.start    = 1'b1;
          div_req.steps    = povls_pkg::STEP_W'(povls_pkg::TONE_W);
          div_req.rem_init = line_wrap;
        end
      end
      povls_pkg::ST_EMIT: begin
        emit_load = ~out_valid_q | out_ready_i;
      end
      povls_pkg::ST_EDGE_DIV, povls_pkg::ST_TONE_DIV: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= povls_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q     <= povls_pkg::LINE_COUNT_RESET;
      frame_count_q    <= povls_pkg::FRAME_COUNT_RESET;
      frame_interval_q <= povls_pkg::FRAME_INTERVAL_RESET;
      min_rotation_q   <= povls_pkg::MIN_ROTATION_RESET;
      displaying_q     <= 1'b0;
      sensor_prev_q    <= 1'b1;
      since_edge_q     <= povls_pkg::SAT_VALUE;
      since_line_q     <= povls_pkg::SAT_VALUE;
      since_frame_q    <= povls_pkg::SAT_VALUE;
      line_time_q      <= povls_pkg::LINE_TIME_RESET;
      line_index_q     <= '0;
      frame_index_q    <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          povls_pkg::REG_LINE_COUNT:
            line_count_q <= cfg_data_i[povls_pkg::LCOUNT_W-1:0];
          povls_pkg::REG_FRAME_COUNT:
            frame_count_q <= cfg_data_i[povls_pkg::FCOUNT_W-1:0];
          povls_pkg::REG_FRAME_INTERVAL:
            frame_interval_q <= cfg_data_i;
          povls_pkg::REG_MIN_ROTATION:
            min_rotation_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (tick_acc) begin
        sensor_prev_q <= sensor_level_i;
        since_edge_q  <= edge_hit ? '0 : se_inc;
        since_line_q  <= sl_inc;
        since_frame_q <= frame_hit ? '0 : sf_inc;
        if (edge_hit) begin
          line_index_q <= '0;
        end
        if (frame_hit) begin
          frame_index_q <= frame_adv;
        end
      end

      if (start_acc) begin
        displaying_q  <= 1'b1;
        line_index_q  <= '0;
        frame_index_q <= '0;
      end

      if ((state_q == povls_pkg::ST_EDGE_DIV) && !div_busy) begin
        line_time_q <= div_quot;
      end

      if (line_hit) begin
        since_line_q  <= '0;
        line_index_q  <= line_wrap + 1'b1;
        frame_index_q <= frame_wrap;
      end

      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_hit) begin
      first_q <= (line_wrap == '0);
    end
    if (emit_load) begin
      led_q       <= povls_pkg::PAT_W'(ram_rdata);
      tone_q      <= div_quot[povls_pkg::TONE_W-1:0];
      first_out_q <= first_q;
    end
  end

  povls_ram #(
    .WIDTH (povls_pkg::LED_COUNT),
    .DEPTH (povls_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (povls_pkg::LED_COUNT'(load_pattern_i)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  povls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign led_pattern_o = led_q;
  assign first_line_o  = first_out_q;
  assign tone_select_o = tone_q;

endmodule

// File: dv/povls_line_checker.sv
`timescale 1ns / 100ps
// Line checker for the LED line sequencer: watches all channels, predicts lines, compares.
module povls_line_checker
  import povls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic                sensor_level_i,
  input  logic [FIDX_W-1:0]   load_frame_i,
  input  logic [LLOAD_W-1:0]  load_line_i,
  input  logic [PAT_W-1:0]    load_pattern_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [PAT_W-1:0]    led_pattern_i,
  input  logic                first_line_i,
  input  logic [TONE_W-1:0]   tone_select_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]    cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  lines_checked_o
);

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic              is_first;
    logic [TONE_W-1:0] tone;
  } led_line_t;

  logic [PAT_W-1:0]    pattern_mem [STORE_DEPTH];
  logic                show_on;
  logic                reed_prev;
  logic [CNT_W-1:0]    edge_age;
  logic [CNT_W-1:0]    line_age;
  logic [CNT_W-1:0]    frame_age;
  logic [CNT_W-1:0]    line_period;
  int unsigned         line_pos;
  int unsigned         frame_pos;
  logic [LCOUNT_W-1:0] lines_reg;
  logic [FCOUNT_W-1:0] frames_reg;
  logic [CNT_W-1:0]    frame_gap;
  logic [CNT_W-1:0]    edge_guard;
  led_line_t           lines_due [$];
  int                  fails = 0;
  int                  checked = 0;

  function automatic int unsigned lines_in_use();
    if (lines_reg == 0) return 1;
    if (lines_reg > LINES_MAX) return LINES_MAX;
    return 32'(lines_reg);
  endfunction

  function automatic int unsigned frames_in_use();
    if (frames_reg == 0) return 1;
    if (frames_reg > FRAMES_MAX) return FRAMES_MAX;
    return 32'(frames_reg);
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == SAT_VALUE) ? v : v + 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    led_line_t   want;
    led_line_t   nxt;
    int unsigned nl;
    if (!rst_ni) begin
      show_on     = 1'b0;
      reed_prev   = 1'b1;
      edge_age    = SAT_VALUE;
      line_age    = SAT_VALUE;
      frame_age   = SAT_VALUE;
      line_period = LINE_TIME_RESET;
      line_pos    = 0;
      frame_pos   = 0;
      lines_reg   = LINE_COUNT_RESET;
      frames_reg  = FRAME_COUNT_RESET;
      frame_gap   = FRAME_INTERVAL_RESET;
      edge_guard  = MIN_ROTATION_RESET;
      lines_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LINE_COUNT:     lines_reg = cfg_data_i[LCOUNT_W-1:0];
          REG_FRAME_COUNT:    frames_reg = cfg_data_i[FCOUNT_W-1:0];
          REG_FRAME_INTERVAL: frame_gap = cfg_data_i;
          REG_MIN_ROTATION:   edge_guard = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          OP_LOAD: pattern_mem[{load_frame_i, load_line_i}] = load_pattern_i;
          OP_START: begin
            show_on   = 1'b1;
            line_pos  = 0;
            frame_pos = 0;
          end
          OP_TICK: begin
            edge_age  = bump(edge_age);
            line_age  = bump(line_age);
            frame_age = bump(frame_age);
            if (reed_prev && !sensor_level_i && edge_age > edge_guard) begin
              line_period = edge_age / lines_in_use();
              line_pos    = 0;
              edge_age    = '0;
            end
            reed_prev = sensor_level_i;
            if (show_on) begin
              if (frame_age > frame_gap) begin
                frame_age = '0;
                frame_pos++;
                if (frame_pos >= frames_in_use()) frame_pos = 0;
              end
              if (line_age > line_period) begin
                nl       = lines_in_use();
                line_age = '0;
                if (line_pos >= nl) line_pos = 0;
                if (frame_pos >= frames_in_use()) frame_pos = 0;
                nxt.pattern  = pattern_mem[ADDR_W'(frame_pos * LINES_MAX + line_pos)];
                nxt.is_first = (line_pos == 0);
                nxt.tone     = TONE_W'((line_pos * TONE_LEVELS) / nl);
                lines_due.insert(lines_due.size(), nxt);
                line_pos++;
              end
            end
          end
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (lines_due.size() == 0) begin
          $error("unexpected line: led_pattern %h first_line %b tone_select %0d",
                 led_pattern_i, first_line_i, tone_select_i);
          fails++;
        end else begin
          want = lines_due.pop_front();
          if (led_pattern_i !== want.pattern) begin
            $error("led_pattern: expected %h, actual %h", want.pattern, led_pattern_i);
            fails++;
          end
          if (first_line_i !== want.is_first) begin
            $error("first_line: expected %b, actual %b", want.is_first, first_line_i);
            fails++;
          end
          if (tone_select_i !== want.tone) begin
            $error("tone_select: expected %0d, actual %0d", want.tone, tone_select_i);
            fails++;
          end
          checked++;
        end
      end
    end
    pending_o       = lines_due.size();
    fail_count_o    = fails;
    lines_checked_o = checked;
  end

endmodule

// File: dv/pov_rotating_led_line_sequencer_test.sv
`timescale 1ns / 100ps
// Testbench top for the LED line sequencer: clock, reset, stimulus and verdict.
module pov_rotating_led_line_sequencer_test;
  import povls_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_MAX      = 8;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned PHASE_ITEMS   = 82;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      operation = OP_TICK;
  logic                 sensor_level = 1'b1;
  logic [FIDX_W-1:0]    load_frame = '0;
  logic [LLOAD_W-1:0]   load_line = '0;
  logic [PAT_W-1:0]     load_pattern = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PAT_W-1:0]     led_pattern;
  logic                 first_line;
  logic [TONE_W-1:0]    tone_select;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_COUNT;
  logic [CNT_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  int lines_checked;

  bit          calm = 1'b0;
  bit          stored [FRAMES_MAX][LINES_MAX];
  int unsigned lines_now = 1;
  int unsigned frames_now = 1;
  int unsigned rev_base = 8;
  int unsigned rev_len = 8;
  int unsigned rev_pos = 0;
  int unsigned low_len = 1;
  int n_ticks = 0;
  int n_loads = 0;
  int n_starts = 0;
  int n_other = 0;
  int n_settings = 0;

  pov_rotating_led_line_sequencer i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .sensor_level_i (sensor_level),
    .load_frame_i   (load_frame),
    .load_line_i    (load_line),
    .load_pattern_i (load_pattern),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .led_pattern_o  (led_pattern),
    .first_line_o   (first_line),
    .tone_select_o  (tone_select),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  povls_line_checker u_line_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .sensor_level_i  (sensor_level),
    .load_frame_i    (load_frame),
    .load_line_i     (load_line),
    .load_pattern_i  (load_pattern),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .led_pattern_i   (led_pattern),
    .first_line_i    (first_line),
    .tone_select_i   (tone_select),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .lines_checked_o (lines_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : line_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [PAT_W-1:0] rand_pattern();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return PAT_W'(1) << $urandom_range(0, PAT_W - 1);
      default: return raw[PAT_W-1:0];
    endcase
  endfunction

  function automatic logic reed_level();
    logic lvl;
    lvl = (rev_pos >= low_len);
    rev_pos++;
    if (rev_pos >= rev_len) begin
      rev_pos = 0;
      rev_len = rev_base + $urandom_range(0, 2);
      low_len = $urandom_range(1, (rev_len > 4) ? 3 : rev_len - 1);
    end
    return lvl;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic lvl,
                           input logic [FIDX_W-1:0] fr, input logic [LLOAD_W-1:0] ln,
                           input logic [PAT_W-1:0] pat);
    int gap;
    gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    sensor_level <= lvl;
    load_frame   <= fr;
    load_line    <= ln;
    load_pattern <= pat;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_TICK:  n_ticks++;
      OP_LOAD:  n_loads++;
      OP_START: n_starts++;
      default:  n_other++;
    endcase
  endtask

  task automatic tick(input logic lvl);
    send_item(OP_TICK, lvl, FIDX_W'($urandom), LLOAD_W'($urandom), rand_pattern());
  endtask

  task automatic load_entry(input int unsigned fr, input int unsigned ln,
                            input logic [PAT_W-1:0] pat);
    send_item(OP_LOAD, 1'($urandom), FIDX_W'(fr), LLOAD_W'(ln), pat);
    stored[FIDX_W'(fr)][LLOAD_W'(ln)] = 1'b1;
  endtask

  task automatic start_display();
    send_item(OP_START, 1'($urandom), FIDX_W'($urandom), LLOAD_W'($urandom), rand_pattern());
  endtask

  // hold off the sender until every predicted line is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_registers(input logic [LCOUNT_W-1:0] lc, input logic [FCOUNT_W-1:0] fc,
                               input logic [CNT_W-1:0] gap_us,
                               input logic [CNT_W-1:0] guard_us);
    logic [CNT_W-1:0] noise;
    noise = $urandom;
    cfg_write(REG_LINE_COUNT, {noise[CNT_W-1:LCOUNT_W], lc});
    cfg_write(REG_FRAME_COUNT, {noise[CNT_W-1:FCOUNT_W], fc});
    cfg_write(REG_FRAME_INTERVAL, gap_us);
    cfg_write(REG_MIN_ROTATION, guard_us);
    cfg_valid <= 1'b0;
    lines_now  = (lc == 0) ? 1 : ((lc > LINES_MAX) ? LINES_MAX : lc);
    frames_now = (fc == 0) ? 1 : ((fc > FRAMES_MAX) ? FRAMES_MAX : fc);
    n_settings++;
  endtask

  // write every entry the display can reach under the current counts
  task automatic fill_store();
    for (int unsigned f = 0; f < frames_now; f++) begin
      for (int unsigned l = 0; l < lines_now; l++) begin
        if (!stored[FIDX_W'(f)][LLOAD_W'(l)]) load_entry(f, l, rand_pattern());
      end
    end
  endtask

  task automatic play_setting(input logic [LCOUNT_W-1:0] lc, input logic [FCOUNT_W-1:0] fc,
                              input logic [CNT_W-1:0] gap_us, input logic [CNT_W-1:0] guard_us,
                              input int unsigned base);
    int roll;
    drain();
    set_registers(lc, fc, gap_us, guard_us);
    fill_store();
    rev_base = base;
    if ($urandom_range(0, 1)) start_display();
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      roll = $urandom_range(0, 99);
      if (roll < 80) tick(reed_level());
      else if (roll < 87) tick(1'($urandom));
      else if (roll < 94) load_entry($urandom_range(0, FRAMES_MAX - 1),
                                     $urandom_range(0, LINES_MAX - 1), rand_pattern());
      else if (roll < 97) start_display();
      else send_item(OP_UNUSED, 1'($urandom), FIDX_W'($urandom), LLOAD_W'($urandom),
                     rand_pattern());
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_UNUSED, 1'b1, '1, '1, '1);
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    drain();
    set_registers(7'd4, 5'd2, 32'd3, 32'd5);
    load_entry(0, 0, '1);
    load_entry(0, 1, '0);
    load_entry(0, 2, 48'h8000_0000_0000);
    load_entry(0, 3, 48'h0000_0000_0001);
    load_entry(1, 0, 48'hAAAA_AAAA_AAAA);
    load_entry(1, 1, 48'h5555_5555_5555);
    load_entry(1, 2, rand_pattern());
    load_entry(1, 3, rand_pattern());
    load_entry(FRAMES_MAX - 1, LINES_MAX - 1, '1);
    start_display();
    for (int k = 0; k < 10; k++) tick((k % 8) != 0);
    start_display();
    for (int k = 0; k < 4; k++) tick(k != 0);

    play_setting(7'd8, 5'd3, 32'd20, 32'd10, 24);
    play_setting(7'd0, 5'd0, 32'd0, 32'd0, 5);
    play_setting(7'd127, 5'd1, '1, 32'd0, 40);
    play_setting(7'd1, 5'd31, 32'd0, 32'd3, 12);
    play_setting(7'd2, 5'd16, 32'd5, '1, 30);
    calm = 1'b1;
    play_setting(7'd64, 5'd1, 32'd7, 32'd2, 3);
    calm = 1'b0;
    for (int p = 0; p < 4; p++) begin
      play_setting(LCOUNT_W'($urandom_range(1, 12)), FCOUNT_W'($urandom_range(1, 4)),
                   $urandom_range(0, 60), $urandom_range(0, 30),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(3, 5) : $urandom_range(6, 60));
    end
    drain();

    $display("Covered %0d register settings with %0d ticks, %0d loads, %0d starts, %0d others.",
             n_settings, n_ticks, n_loads, n_starts, n_other);
    $display("Compared %0d emitted lines against the prediction.", lines_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/povls_pkg.sv
rtl/core/povls_ram.sv
rtl/core/povls_div.sv
rtl/core/pov_rotating_led_line_sequencer.sv
dv/povls_line_checker.sv
dv/pov_rotating_led_line_sequencer_test.sv
